// ===== rtl/ehc_pkg.sv =====
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types, constants and helpers of the Ethernet/IP header classifier.
// ----------------------------------------------------------------------------
package ehc_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	// Byte counter holds 0 .. MAX_FRAME_BYTES.
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	// Header offsets may run past the frame by up to one maximal extension header.
	localparam int POS_W = ((CNT_W > 12) ? CNT_W : 12) + 1;

	localparam int CLASS_W = 3;
	localparam int L2_W    = 5;
	localparam int L3_W    = 12;

	typedef enum logic [2:0] {
		PH_ETH   = 3'd0,
		PH_VLAN  = 3'd1,
		PH_IP4   = 3'd2,
		PH_IP6   = 3'd3,
		PH_OTHER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EXT_NONE    = 2'd0,
		EXT_GENERIC = 2'd1,
		EXT_FRAG    = 2'd2,
		EXT_AH      = 2'd3
	} ext_kind_t;

	localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_ARP     = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_IP4_TCP = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_IP4_UDP = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_IP6_TCP = 3'd4;
	localparam logic [CLASS_W-1:0] CLS_IP6_UDP = 3'd5;
	localparam logic [CLASS_W-1:0] CLS_IP6_ICMP = 3'd6;

	localparam logic [15:0] ETYPE_IP4  = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_IP6  = 16'h86DD;

	localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
	localparam logic [7:0] PROTO_IPIP     = 8'd4;
	localparam logic [7:0] PROTO_TCP      = 8'd6;
	localparam logic [7:0] PROTO_UDP      = 8'd17;
	localparam logic [7:0] PROTO_IP6IP6   = 8'd41;
	localparam logic [7:0] PROTO_ROUTING  = 8'd43;
	localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
	localparam logic [7:0] PROTO_AH       = 8'd51;
	localparam logic [7:0] PROTO_ICMP6    = 8'd58;
	localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
	localparam logic [7:0] PROTO_MOBILITY = 8'd135;
	localparam logic [7:0] PROTO_HIP      = 8'd139;
	localparam logic [7:0] PROTO_SHIM6    = 8'd140;

	localparam logic [7:0] IHL_MASK = 8'h0f;

	localparam logic [L2_W-1:0] ETH_HDR_LEN  = 5'd14;
	localparam logic [L2_W-1:0] VLAN_HDR_LEN = 5'd18;

	typedef struct packed {
		logic              dropped;
		logic [7:0]        final_proto;
		logic [L3_W-1:0]   l3_length;
		logic [L2_W-1:0]   l2_length;
		logic [CLASS_W-1:0] pkt_class;
	} result_t;

	function automatic ext_kind_t ext_kind(input logic [7:0] p);
		ext_kind_t k;
		k = EXT_NONE;
		if (p == PROTO_HOPOPT || p == PROTO_ROUTING || p == PROTO_DSTOPTS ||
		    p == PROTO_MOBILITY || p == PROTO_HIP || p == PROTO_SHIM6) begin
			k = EXT_GENERIC;
		end else if (p == PROTO_FRAGMENT) begin
			k = EXT_FRAG;
		end else if (p == PROTO_AH) begin
			k = EXT_AH;
		end
		return k;
	endfunction

endpackage

// ===== rtl/ehc_parser.sv =====
// ----------------------------------------------------------------------------
// ehc_parser
// Per-frame header state, updated once per accepted byte, with the
// classification of the frame worked out on its last byte.
// ----------------------------------------------------------------------------
module ehc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat,
	input  logic [7:0]        data_byte,
	input  logic              last,
	input  logic              ipv6_enable,
	output logic              res_valid,
	output ehc_pkg::result_t  res
);
	import ehc_pkg::*;

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [15:0]       ftype_q, ftype_d;
	logic [L2_W-1:0]   link_q, link_d;
	logic [POS_W-1:0]  nhe_q, nhe_d;
	logic [7:0]        proto_q, proto_d;
	logic [POS_W-1:0]  ehs_q, ehs_d;
	logic [7:0]        held_q, held_d;
	logic              known_q, known_d;

	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  link_pos;
	logic [POS_W-1:0]  avail;
	logic [POS_W-1:0]  hdr;
	logic [POS_W-1:0]  rest;
	logic              do_dispatch;
	ext_kind_t         kind;

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		ftype_d     = ftype_q;
		link_d      = link_q;
		nhe_d       = nhe_q;
		proto_d     = proto_q;
		ehs_d       = ehs_q;
		held_d      = held_q;
		known_d     = known_q;
		do_dispatch = 1'b0;
		kind        = EXT_NONE;
		pos         = POS_W'(count_q);
		link_pos    = POS_W'(link_q);
		avail       = '0;
		hdr         = '0;
		rest        = '0;
		res         = '0;
		res_valid   = 1'b0;

		if (beat) begin
			if (count_q < CNT_W'(MAX_FRAME_BYTES)) begin
				count_d = count_q + CNT_W'(1);
				unique case (phase_q)
					PH_ETH: begin
						if (pos == POS_W'(12)) begin
							ftype_d = {data_byte, 8'h00};
						end else if (pos == POS_W'(13)) begin
							ftype_d = {ftype_q[15:8], data_byte};
							if (ftype_d == ETYPE_VLAN) begin
								link_d  = VLAN_HDR_LEN;
								phase_d = PH_VLAN;
							end else begin
								link_d      = ETH_HDR_LEN;
								do_dispatch = 1'b1;
							end
						end
					end
					PH_VLAN: begin
						if (pos == POS_W'(16)) begin
							ftype_d = {data_byte, 8'h00};
						end else if (pos == POS_W'(17)) begin
							ftype_d     = {ftype_q[15:8], data_byte};
							do_dispatch = 1'b1;
						end
					end
					PH_IP4: begin
						if (pos == link_pos) begin
							nhe_d = link_pos + POS_W'({(data_byte & IHL_MASK), 2'b00});
						end else if (pos == link_pos + POS_W'(9)) begin
							proto_d = data_byte;
						end
					end
					PH_IP6: begin
						if (pos == link_pos + POS_W'(6)) begin
							proto_d = data_byte;
						end
						if (pos >= ehs_q) begin
							kind = ext_kind(proto_d);
							// The current extension header ends here: step to the next one.
							if (kind != EXT_NONE && known_q && pos == nhe_q) begin
								proto_d = held_q;
								ehs_d   = pos;
								known_d = 1'b0;
								kind    = ext_kind(proto_d);
							end
							if (kind != EXT_NONE) begin
								if (pos == ehs_d) begin
									held_d = data_byte;
									if (kind == EXT_FRAG) begin
										nhe_d   = pos + POS_W'(8);
										known_d = 1'b1;
									end
								end else if (pos == ehs_d + POS_W'(1) && kind != EXT_FRAG) begin
									if (kind == EXT_GENERIC) begin
										nhe_d = ehs_d + {(POS_W-3)'(data_byte) + (POS_W-3)'(1), 3'b000};
									end else begin
										nhe_d = ehs_d + {(POS_W-2)'(data_byte) + (POS_W-2)'(2), 2'b00};
									end
									known_d = 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase

				if (do_dispatch) begin
					if (ftype_d == ETYPE_IP4) begin
						phase_d = PH_IP4;
					end else if (ftype_d == ETYPE_IP6 && ipv6_enable) begin
						phase_d = PH_IP6;
						ehs_d   = POS_W'(link_d) + POS_W'(40);
						known_d = 1'b0;
					end else begin
						phase_d = PH_OTHER;
					end
				end
			end

			if (last) begin
				res_valid = 1'b1;
				if (phase_d != PH_ETH && phase_d != PH_VLAN) begin
					res.l2_length = link_d;
					avail = POS_W'(count_d) - POS_W'(link_d);
					unique case (phase_d)
						PH_OTHER: begin
							if (ftype_d == ETYPE_ARP) begin
								res.pkt_class = CLS_ARP;
							end
						end
						PH_IP4: begin
							hdr  = nhe_d - POS_W'(link_d);
							rest = avail - hdr;
							if (avail >= POS_W'(20) && avail >= hdr) begin
								res.l3_length   = hdr[L3_W-1:0];
								res.final_proto = proto_d;
								if (proto_d == PROTO_TCP) begin
									res.pkt_class = (rest >= POS_W'(20)) ? CLS_IP4_TCP : CLS_UNKNOWN;
								end else if (proto_d == PROTO_UDP) begin
									res.pkt_class = (rest >= POS_W'(8)) ? CLS_IP4_UDP : CLS_UNKNOWN;
								end else if (proto_d != PROTO_IPIP) begin
									res.dropped = 1'b1;
								end
							end
						end
						default: begin
							// A chain still inside an extension header is cut at frame end.
							if (ext_kind(proto_d) != EXT_NONE) begin
								hdr = avail;
							end else begin
								hdr = ehs_d - POS_W'(link_d);
							end
							rest = avail - hdr;
							if (avail >= POS_W'(40)) begin
								res.l3_length   = hdr[L3_W-1:0];
								res.final_proto = proto_d;
								if (proto_d == PROTO_TCP) begin
									res.pkt_class = CLS_IP6_TCP;
								end else if (proto_d == PROTO_UDP) begin
									res.pkt_class = CLS_IP6_UDP;
								end else if (proto_d == PROTO_ICMP6) begin
									res.pkt_class = (rest >= POS_W'(8)) ? CLS_IP6_ICMP : CLS_UNKNOWN;
								end else if (proto_d != PROTO_IP6IP6) begin
									res.dropped = 1'b1;
								end
							end
						end
					endcase
				end

				phase_d = PH_ETH;
				count_d = '0;
				ftype_d = '0;
				link_d  = ETH_HDR_LEN;
				nhe_d   = '0;
				proto_d = '0;
				ehs_d   = '0;
				held_d  = '0;
				known_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ETH;
			count_q <= '0;
			ftype_q <= '0;
			link_q  <= ETH_HDR_LEN;
			nhe_q   <= '0;
			proto_q <= '0;
			ehs_q   <= '0;
			held_q  <= '0;
			known_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			ftype_q <= ftype_d;
			link_q  <= link_d;
			nhe_q   <= nhe_d;
			proto_q <= proto_d;
			ehs_q   <= ehs_d;
			held_q  <= held_d;
			known_q <= known_d;
		end
	end

endmodule

// ===== rtl/ehc_out_reg.sv =====
// ----------------------------------------------------------------------------
// ehc_out_reg
// Result register with one skid entry, so the input keeps flowing while a
// result waits for the sink.
// ----------------------------------------------------------------------------
module ehc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ehc_pkg::result_t  in_res,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output ehc_pkg::result_t  out_res
);
	import ehc_pkg::*;

	logic    main_valid_q;
	result_t main_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign room      = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || out_ready) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= in_valid;
				end
			end else if (in_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			main_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

endmodule

// ===== rtl/ethernet_ip_header_classifier.sv =====
// ----------------------------------------------------------------------------
// ethernet_ip_header_classifier
// Byte-wide Ethernet/VLAN/IPv4/IPv6 header parser giving one classification
// beat per frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     s_tdata = data_byte, s_tlast = last
//  m_*      out  m_tvalid / m_tready     m_tdata = classification result
//  cfg_*    in   cfg_valid / cfg_ready   cfg_data = ipv6_enable
//
// One byte is taken every cycle while s_tready is high; the per-byte state
// update and, on the last byte, the classification are combinational ahead
// of the result register. A skid entry keeps s_tready high while one result
// is held up by m_tready low.
// After reset ipv6_enable is 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ethernet_ip_header_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] pkt_class, [7:3] l2_length, [19:8] l3_length, [27:20] final_proto,
	// [28] dropped, [31:29] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // [0] ipv6_enable
);
	import ehc_pkg::*;

	logic    ipv6_enable_q;
	logic    beat;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign cfg_ready = 1'b1;
	assign beat      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv6_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			ipv6_enable_q <= cfg_data;
		end
	end

	ehc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat),
		.data_byte   (s_tdata),
		.last        (s_tlast),
		.ipv6_enable (ipv6_enable_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	ehc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {3'b000, out_res};

endmodule

// ===== bench/classification_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// classification_checker
// Follows every byte beat that enters the header classifier, works out the
// classification that each frame should get, and compares it field by field
// with the result beats that leave the block, oldest first.
// ----------------------------------------------------------------------------
module classification_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] pkt_class, [7:3] l2_length, [19:8] l3_length, [27:20] final_proto,
	// [28] dropped, [31:29] zero
	input  logic [31:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          fail_count,
	output int          pending
);
	import ehc_pkg::*;

	// Parser state of the frame in flight.
	phase_t      stage;
	int          nbytes;
	int          l2len;
	int          hdr_end;
	int          ext_start;
	logic [15:0] etype;
	logic [7:0]  chain_nh;
	logic [7:0]  held_nh;
	bit          hdr_end_known;
	bit          v6_on;

	result_t     predicted_results[$];
	result_t     want;
	result_t     seen;
	int          mism = 0;

	function automatic ext_kind_t header_kind(input logic [7:0] p);
		case (p)
			PROTO_HOPOPT, PROTO_ROUTING, PROTO_DSTOPTS,
			PROTO_MOBILITY, PROTO_HIP, PROTO_SHIM6: return EXT_GENERIC;
			PROTO_FRAGMENT:                         return EXT_FRAG;
			PROTO_AH:                               return EXT_AH;
			default:                                return EXT_NONE;
		endcase
	endfunction

	task automatic rearm();
		stage         = PH_ETH;
		nbytes        = 0;
		etype         = '0;
		l2len         = int'(ETH_HDR_LEN);
		hdr_end       = 0;
		chain_nh      = '0;
		ext_start     = 0;
		held_nh       = '0;
		hdr_end_known = 1'b0;
	endtask

	task automatic pick_network();
		if (etype == ETYPE_IP4) begin
			stage = PH_IP4;
		end else if (etype == ETYPE_IP6 && v6_on) begin
			stage         = PH_IP6;
			ext_start     = l2len + 40;
			hdr_end_known = 1'b0;
		end else begin
			stage = PH_OTHER;
		end
	endtask

	task automatic parse_byte(input int pos, input logic [7:0] b);
		int        off;
		ext_kind_t k;
		off = pos - l2len;
		case (stage)
			PH_ETH: begin
				if (pos == 12) begin
					etype = {b, 8'h00};
				end else if (pos == 13) begin
					etype[7:0] = b;
					if (etype == ETYPE_VLAN) begin
						l2len = int'(VLAN_HDR_LEN);
						stage = PH_VLAN;
					end else begin
						l2len = int'(ETH_HDR_LEN);
						pick_network();
					end
				end
			end
			PH_VLAN: begin
				if (pos == 16) begin
					etype = {b, 8'h00};
				end else if (pos == 17) begin
					etype[7:0] = b;
					pick_network();
				end
			end
			PH_IP4: begin
				if (off == 0) begin
					hdr_end = l2len + 4 * int'(b & IHL_MASK);
				end else if (off == 9) begin
					chain_nh = b;
				end
			end
			PH_IP6: begin
				if (off == 6) begin
					chain_nh = b;
				end
				k = header_kind(chain_nh);
				if (pos >= ext_start && k != EXT_NONE) begin
					// The current extension header ends here: move on to the one it names.
					if (hdr_end_known && pos == hdr_end) begin
						chain_nh      = held_nh;
						ext_start     = pos;
						hdr_end_known = 1'b0;
						k             = header_kind(chain_nh);
					end
					if (k != EXT_NONE) begin
						if (pos == ext_start) begin
							held_nh = b;
							if (k == EXT_FRAG) begin
								hdr_end       = pos + 8;
								hdr_end_known = 1'b1;
							end
						end else if (pos == ext_start + 1 && k != EXT_FRAG) begin
							if (k == EXT_GENERIC) begin
								hdr_end = ext_start + (int'(b) + 1) * 8;
							end else begin
								hdr_end = ext_start + (int'(b) + 2) * 4;
							end
							hdr_end_known = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic classify_frame(output result_t r);
		int avail;
		int hdr;
		int rest;
		r = '0;
		if (stage != PH_ETH && stage != PH_VLAN) begin
			r.l2_length = l2len[L2_W-1:0];
			avail       = nbytes - l2len;
			case (stage)
				PH_OTHER: begin
					if (etype == ETYPE_ARP) begin
						r.pkt_class = CLS_ARP;
					end
				end
				PH_IP4: begin
					hdr = hdr_end - l2len;
					if (avail >= 20 && avail >= hdr) begin
						rest          = avail - hdr;
						r.l3_length   = hdr[L3_W-1:0];
						r.final_proto = chain_nh;
						if (chain_nh == PROTO_TCP) begin
							if (rest >= 20) r.pkt_class = CLS_IP4_TCP;
						end else if (chain_nh == PROTO_UDP) begin
							if (rest >= 8) r.pkt_class = CLS_IP4_UDP;
						end else if (chain_nh != PROTO_IPIP) begin
							r.dropped = 1'b1;
						end
					end
				end
				PH_IP6: begin
					if (avail >= 40) begin
						// A walk still inside an extension header is cut off at the frame end.
						if (header_kind(chain_nh) != EXT_NONE) begin
							hdr = avail;
						end else begin
							hdr = ext_start - l2len;
						end
						rest          = avail - hdr;
						r.l3_length   = hdr[L3_W-1:0];
						r.final_proto = chain_nh;
						if (chain_nh == PROTO_TCP) begin
							r.pkt_class = CLS_IP6_TCP;
						end else if (chain_nh == PROTO_UDP) begin
							r.pkt_class = CLS_IP6_UDP;
						end else if (chain_nh == PROTO_ICMP6) begin
							if (rest >= 8) r.pkt_class = CLS_IP6_ICMP;
						end else if (chain_nh != PROTO_IP6IP6) begin
							r.dropped = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_field(input string what, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
			mism++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm();
			v6_on = 1'b1;
			predicted_results.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				v6_on = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				// Bytes past the longest frame are not parsed but still end the frame.
				if (nbytes < MAX_FRAME_BYTES) begin
					parse_byte(nbytes, s_tdata);
					nbytes++;
				end
				if (s_tlast) begin
					classify_frame(want);
					predicted_results.push_back(want);
					rearm();
				end
			end
			if (m_tvalid && m_tready) begin
				seen = result_t'(m_tdata[28:0]);
				if (predicted_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none, actual %h",
						$time, m_tdata);
					mism++;
				end else begin
					want = predicted_results.pop_front();
					check_field("pkt_class", int'(want.pkt_class), int'(seen.pkt_class));
					check_field("l2_length", int'(want.l2_length), int'(seen.l2_length));
					check_field("l3_length", int'(want.l3_length), int'(seen.l3_length));
					check_field("final_proto", int'(want.final_proto),
						int'(seen.final_proto));
					check_field("dropped", int'(want.dropped), int'(seen.dropped));
					check_field("tdata padding", 0, int'(m_tdata[31:29]));
				end
			end
			pending    <= predicted_results.size();
			fail_count <= mism;
		end
	end

endmodule

// ===== bench/tb_ethernet_ip_header_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ethernet_ip_header_classifier
// Feeds the header classifier with hand-built and random Ethernet, VLAN, ARP,
// IPv4 and IPv6 frames under random stalls on both sides, switches IPv6
// support off and on between runs, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_ethernet_ip_header_classifier;
	import ehc_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	int          fail_count;
	int          pending;
	int          stall_cycles = 0;
	int          bytes_sent = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;
	logic [7:0]  frame_buf[$];

	ethernet_ip_header_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	classification_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: random back-pressure, with one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_ext();
		case ($urandom_range(0, 7))
			0:       return PROTO_HOPOPT;
			1:       return PROTO_ROUTING;
			2:       return PROTO_DSTOPTS;
			3:       return PROTO_FRAGMENT;
			4:       return PROTO_AH;
			5:       return PROTO_MOBILITY;
			6:       return PROTO_HIP;
			default: return PROTO_SHIM6;
		endcase
	endfunction

	function automatic logic [7:0] pick_l4();
		case ($urandom_range(0, 6))
			0, 1:    return PROTO_TCP;
			2, 3:    return PROTO_UDP;
			4:       return PROTO_ICMP6;
			5:       return ($urandom_range(0, 1) != 0) ? PROTO_IPIP : PROTO_IP6IP6;
			default: return rnd_byte();
		endcase
	endfunction

	task automatic add_payload(input int n);
		for (int i = 0; i < n; i++) begin
			frame_buf.push_back(rnd_byte());
		end
	endtask

	task automatic start_frame(input bit vlan, input logic [15:0] etype);
		frame_buf.delete();
		add_payload(12);
		if (vlan) begin
			frame_buf.push_back(ETYPE_VLAN[15:8]);
			frame_buf.push_back(ETYPE_VLAN[7:0]);
			add_payload(2);
		end
		frame_buf.push_back(etype[15:8]);
		frame_buf.push_back(etype[7:0]);
	endtask

	task automatic add_ipv4(input logic [3:0] ihl, input logic [7:0] proto);
		int         hlen;
		logic [3:0] vers;
		hlen = (ihl * 4 < 20) ? 20 : ihl * 4;
		vers = 4'($urandom_range(0, 15));
		frame_buf.push_back({vers, ihl});
		for (int i = 1; i < hlen; i++) begin
			frame_buf.push_back((i == 9) ? proto : rnd_byte());
		end
	endtask

	task automatic add_ipv6(input logic [7:0] nh);
		for (int i = 0; i < 40; i++) begin
			frame_buf.push_back((i == 6) ? nh : rnd_byte());
		end
	endtask

	task automatic add_ext(input logic [7:0] kind_p, input logic [7:0] nh, input logic [7:0] n);
		int len;
		case (kind_p)
			PROTO_FRAGMENT: len = 8;
			PROTO_AH:       len = (int'(n) + 2) * 4;
			default:        len = (int'(n) + 1) * 8;
		endcase
		frame_buf.push_back(nh);
		frame_buf.push_back((kind_p == PROTO_FRAGMENT) ? rnd_byte() : n);
		add_payload(len - 2);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l);
		while (!steady && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Sends the frame in the buffer, cut short after 'cut' bytes when that is nonzero.
	task automatic send_frame(input int cut);
		int n;
		n = (cut > 0 && cut < frame_buf.size()) ? cut : frame_buf.size();
		for (int i = 0; i < n; i++) begin
			send_byte(frame_buf[i], i == n - 1);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_ipv6_enable(input logic en);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_frame();
		int          pick;
		int          n_ext;
		int          cut;
		bit          vlan;
		logic [3:0]  ihl;
		logic [7:0]  nh;
		logic [7:0]  next_nh;
		logic [7:0]  n;
		logic [15:0] et;
		pick = $urandom_range(0, 99);
		vlan = ($urandom_range(0, 3) == 0);
		cut  = 0;
		if (pick < 8) begin
			// Line noise, often too short for a whole link header.
			frame_buf.delete();
			add_payload($urandom_range(1, 80));
		end else if (pick < 18) begin
			et = 16'($urandom_range(0, 65535));
			case ($urandom_range(0, 2))
				0:       start_frame(vlan, ETYPE_ARP);
				1:       start_frame(1'b1, ETYPE_VLAN);
				default: start_frame(vlan, et);
			endcase
			add_payload($urandom_range(0, 50));
		end else if (pick < 50) begin
			ihl = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 3) != 0) ihl = 4'd5;
			start_frame(vlan, ETYPE_IP4);
			add_ipv4(ihl, pick_l4());
			add_payload($urandom_range(0, 30));
		end else begin
			n_ext = $urandom_range(0, 3);
			nh    = (n_ext > 0) ? pick_ext() : pick_l4();
			start_frame(vlan, ETYPE_IP6);
			add_ipv6(nh);
			for (int i = 0; i < n_ext; i++) begin
				next_nh = (i == n_ext - 1) ? pick_l4() : pick_ext();
				n       = 8'($urandom_range(0, 2));
				if ($urandom_range(0, 39) == 0) begin
					n   = rnd_byte();
					cut = $urandom_range(60, 200);
				end
				add_ext(nh, next_nh, n);
				nh = next_nh;
			end
			add_payload($urandom_range(0, 20));
		end
		if ($urandom_range(0, 99) < 15) begin
			cut = $urandom_range(1, frame_buf.size());
		end
		send_frame(cut);
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_ipv6_enable(1'b1);

		// Link header cut short, with and without a tag.
		start_frame(1'b0, ETYPE_IP4);
		send_frame(1);
		send_frame(13);
		start_frame(1'b1, ETYPE_IP4);
		send_frame(16);
		// ARP, an unknown type and a second tag, all without payload.
		start_frame(1'b0, ETYPE_ARP);
		send_frame(0);
		start_frame(1'b0, 16'h88B5);
		send_frame(0);
		start_frame(1'b1, ETYPE_VLAN);
		send_frame(0);
		// IPv4 TCP minimum, exactly met and one byte short.
		start_frame(1'b0, ETYPE_IP4);
		add_ipv4(4'd5, PROTO_TCP);
		add_payload(20);
		send_frame(0);
		send_frame(frame_buf.size() - 1);
		// Largest IHL with an unhandled protocol, then an undersized IHL.
		start_frame(1'b0, ETYPE_IP4);
		add_ipv4(4'd15, 8'd1);
		send_frame(0);
		start_frame(1'b1, ETYPE_IP4);
		add_ipv4(4'd2, PROTO_UDP);
		add_payload(8);
		send_frame(0);
		// ICMPv6 minimum, exactly met and one byte short.
		start_frame(1'b0, ETYPE_IP6);
		add_ipv6(PROTO_ICMP6);
		add_payload(8);
		send_frame(0);
		send_frame(frame_buf.size() - 1);

		// A long stretch with no idling on either side.
		steady = 1'b1;
		// Every extension header type in one chain.
		start_frame(1'b0, ETYPE_IP6);
		add_ipv6(PROTO_HOPOPT);
		add_ext(PROTO_HOPOPT, PROTO_ROUTING, 8'd0);
		add_ext(PROTO_ROUTING, PROTO_DSTOPTS, 8'd1);
		add_ext(PROTO_DSTOPTS, PROTO_FRAGMENT, 8'd0);
		add_ext(PROTO_FRAGMENT, PROTO_AH, 8'd0);
		add_ext(PROTO_AH, PROTO_MOBILITY, 8'd1);
		add_ext(PROTO_MOBILITY, PROTO_HIP, 8'd0);
		add_ext(PROTO_HIP, PROTO_SHIM6, 8'd0);
		add_ext(PROTO_SHIM6, PROTO_TCP, 8'd0);
		add_payload(4);
		send_frame(0);
		// Extension header ending at the frame end, then one running past it.
		start_frame(1'b0, ETYPE_IP6);
		add_ipv6(PROTO_ROUTING);
		add_ext(PROTO_ROUTING, PROTO_UDP, 8'd0);
		send_frame(0);
		send_frame(frame_buf.size() - 4);
		steady = 1'b0;

		// IPv6 support switched off.
		set_ipv6_enable(1'b0);
		start_frame(1'b0, ETYPE_IP6);
		add_ipv6(PROTO_TCP);
		send_frame(0);
		repeat (2) random_frame();
		set_ipv6_enable(1'b1);

		for (int f = 0; bytes_sent < 1050 || f < 3; f++) begin
			if (f == 1) begin
				// Keep offering one-byte frames while the result side is held off.
				hold_req = 1'b1;
				start_frame(1'b0, ETYPE_ARP);
				repeat (8) send_frame(1);
			end
			if (f == 2) begin
				drain();
			end
			random_frame();
		end

		drain();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
